// ===== rtl/i2cs_pkg.sv =====
// Types and constants shared by the I2C register transaction sequencer.
// No dependencies.
package i2cs_pkg;

    localparam int WORD_W    = 32;
    localparam int MAX_BYTES = 4;
    localparam int LANES     = WORD_W / 8;
    localparam logic [2:0] CNT_MAX = 3'(MAX_BYTES);

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_ACK   = 2'd1,
        OP_RX    = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        PH_ADDR     = 3'd0,
        PH_REPSTART = 3'd1,
        PH_READ     = 3'd2,
        PH_WRDATA   = 3'd3,
        PH_WAITSTOP = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                busy;
        logic                dir_read;
        logic [2:0]          bytes_left;
        logic [6:0]          target_addr;
        logic [7:0]          target_reg;
        logic [WORD_W-1:0]   word_buffer;
    } t_state;

    typedef struct packed {
        logic                cmd_start;
        logic                cmd_stop;
        logic                cmd_ack;
        logic                cmd_nack;
        logic                tx_valid;
        logic [7:0]          tx_byte;
        logic [WORD_W-1:0]   read_word;
        logic                done_res;
        logic                busy_res;
        logic                seq_error;
    } t_result;

endpackage

// ===== rtl/i2cs_step.sv =====
// Combinational phase update for one bus event or start request.
// Depends on i2cs_pkg.
module i2cs_step import i2cs_pkg::*; (
    input  t_state      i_state,
    input  logic [1:0]  i_opcode,
    input  logic        i_read_mode,
    input  logic [6:0]  i_device_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [2:0]  i_byte_count,
    input  logic [31:0] i_data_word,
    input  logic [7:0]  i_rx_byte,
    output t_state      o_state,
    output t_result     o_result
);

    // lanes beyond the word read as zero and drop writes
    function automatic logic [7:0] lane_get(logic [WORD_W-1:0] word, logic [2:0] lane);
        logic [7:0] b;
        b = '0;
        if (32'(lane) < LANES) begin
            b = word[32'(lane) * 8 +: 8];
        end
        return b;
    endfunction

    function automatic logic [WORD_W-1:0] lane_put(logic [WORD_W-1:0] word,
                                                   logic [2:0] lane, logic [7:0] b);
        logic [WORD_W-1:0] w;
        w = word;
        if (32'(lane) < LANES) begin
            w[32'(lane) * 8 +: 8] = b;
        end
        return w;
    endfunction

    t_opcode    op;
    logic [2:0] cnt;
    logic [2:0] dec;

    assign op  = t_opcode'(i_opcode);
    assign dec = i_state.bytes_left - 3'd1;

    always_comb begin
        cnt = i_byte_count;
        if (cnt == 3'd0) begin
            cnt = 3'd1;
        end
        if (cnt > CNT_MAX) begin
            cnt = CNT_MAX;
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (op == OP_START) begin
            if (i_state.busy) begin
                o_result.seq_error = 1'b1;
            end else begin
                o_state.busy        = 1'b1;
                o_state.dir_read    = i_read_mode;
                o_state.bytes_left  = cnt;
                o_state.target_addr = i_device_addr;
                o_state.target_reg  = i_reg_addr;
                o_state.word_buffer = i_data_word;
                o_state.phase       = PH_ADDR;
                o_result.cmd_start  = 1'b1;
                o_result.tx_valid   = 1'b1;
                o_result.tx_byte    = {i_device_addr, 1'b0};
            end
        end else if (!i_state.busy) begin
            o_result.seq_error = 1'b1;
        end else begin
            unique case (op)
                OP_ACK: begin
                    unique case (i_state.phase)
                        PH_ADDR: begin
                            o_result.tx_valid = 1'b1;
                            o_result.tx_byte  = i_state.target_reg;
                            o_state.phase = i_state.dir_read ? PH_REPSTART : PH_WRDATA;
                        end
                        PH_REPSTART: begin
                            o_result.cmd_start = 1'b1;
                            o_result.tx_valid  = 1'b1;
                            o_result.tx_byte   = {i_state.target_addr, 1'b1};
                            o_state.phase      = PH_READ;
                        end
                        PH_WRDATA: begin
                            o_state.bytes_left = dec;
                            o_result.tx_valid  = 1'b1;
                            o_result.tx_byte   = lane_get(i_state.word_buffer, dec);
                            if (dec == 3'd0) begin
                                o_result.cmd_stop = 1'b1;
                                o_state.phase     = PH_WAITSTOP;
                            end
                        end
                        default: ; // address or last byte acked, nothing to do
                    endcase
                end
                OP_RX: begin
                    if (i_state.phase == PH_READ) begin
                        o_state.bytes_left  = dec;
                        o_state.word_buffer = lane_put(i_state.word_buffer, dec, i_rx_byte);
                        if (dec != 3'd0) begin
                            o_result.cmd_ack = 1'b1;
                        end else begin
                            o_result.cmd_nack = 1'b1;
                            o_result.cmd_stop = 1'b1;
                            o_state.phase     = PH_WAITSTOP;
                        end
                    end else begin
                        o_result.seq_error = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (i_state.phase == PH_WAITSTOP) begin
                        o_state.busy      = 1'b0;
                        o_state.phase     = PH_ADDR;
                        o_result.done_res = 1'b1;
                    end else begin
                        o_result.seq_error = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        o_result.read_word = o_state.word_buffer;
        o_result.busy_res  = o_state.busy;
    end

endmodule

// ===== rtl/i2c_register_transaction_sequencer_unit.sv =====
// I2C register transaction sequencer: top level with state and result registers.
// Depends on i2cs_pkg and i2cs_step.
// The result of an accepted request is in the output register in the next cycle.
// Throughput: one request per cycle; a new request is taken while the output holds
// a result, as long as that result is taken in the same cycle.
// Reset (synchronous, active low): idle, not busy, all state cleared, output empty.
module i2c_register_transaction_sequencer_unit import i2cs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic        i_read_mode,
    input  logic [6:0]  i_device_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [2:0]  i_byte_count,
    input  logic [31:0] i_data_word,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_cmd_start,
    output logic        o_cmd_stop,
    output logic        o_cmd_ack,
    output logic        o_cmd_nack,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic [31:0] o_read_word,
    output logic        o_done_res,
    output logic        o_busy_res,
    output logic        o_seq_error
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    accept;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    i2cs_step u_step (
        .i_state       (r_state),
        .i_opcode      (i_opcode),
        .i_read_mode   (i_read_mode),
        .i_device_addr (i_device_addr),
        .i_reg_addr    (i_reg_addr),
        .i_byte_count  (i_byte_count),
        .i_data_word   (i_data_word),
        .i_rx_byte     (i_rx_byte),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_ADDR, default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_cmd_start = r_result.cmd_start;
    assign o_cmd_stop  = r_result.cmd_stop;
    assign o_cmd_ack   = r_result.cmd_ack;
    assign o_cmd_nack  = r_result.cmd_nack;
    assign o_tx_valid  = r_result.tx_valid;
    assign o_tx_byte   = r_result.tx_byte;
    assign o_read_word = r_result.read_word;
    assign o_done_res  = r_result.done_res;
    assign o_busy_res  = r_result.busy_res;
    assign o_seq_error = r_result.seq_error;

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.busy |-> r_state.phase == PH_ADDR)
        else $error("idle sequencer not in address phase");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bytes_left <= CNT_MAX)
        else $error("byte count above limit");

    a_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.seq_error |->
        !(r_result.cmd_start || r_result.cmd_stop || r_result.cmd_ack ||
          r_result.cmd_nack || r_result.tx_valid || r_result.done_res))
        else $error("error result carries a command");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.done_res |-> !r_result.busy_res && !r_state.busy)
        else $error("done while still busy");

    a_ack_nack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.cmd_ack && r_result.cmd_nack))
        else $error("ack and nack together");

endmodule
